### hw/rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, constants and the CRC-8 byte step for the sensor frame
// CRC check and conversion core.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned POS_W       = 3;
    localparam int unsigned TEMP_W      = 15;
    localparam int unsigned HUM_W       = 14;
    localparam int unsigned TMUL_W      = 31;   // 17500 * 65535 < 2^31
    localparam int unsigned HMUL_W      = 30;   // 10000 * 65535 < 2^30
    localparam int unsigned OUT_TDATA_W = 64;   // 62 payload bits, byte padded

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

    // byte position codes within a frame
    localparam logic [POS_W-1:0] POS_TEMP_MSB = 3'd0;
    localparam logic [POS_W-1:0] POS_TEMP_LSB = 3'd1;
    localparam logic [POS_W-1:0] POS_TEMP_CRC = 3'd2;
    localparam logic [POS_W-1:0] POS_HUM_MSB  = 3'd3;
    localparam logic [POS_W-1:0] POS_HUM_LSB  = 3'd4;
    localparam logic [POS_W-1:0] POS_HUM_CRC  = 3'd5;

    localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd17500;
    localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd4500;
    localparam logic [WORD_W:0]   FULL_SCALE  = 17'd65535;

    typedef struct packed {
        logic              status;
        logic [WORD_W-1:0] temp_word;
        logic [WORD_W-1:0] humidity_word;
    } t_frame_res;

    // CRC-8, MSB first, no final xor; eight narrow dependent steps
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] v;
        v = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            v = v[BYTE_W-1] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage

### hw/rtl/sensor_frame_crc_convert_core.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_convert_core
// Checks the two CRC-8 bytes of a six-byte temperature/humidity frame and
// converts the raw words to hundredths of a degree and of a percent.
//
//   Channel  Dir  Handshake               Payload
//   s_axis   in   s_axis_tvalid/tready    tdata = rx_byte, tuser = frame_start
//   m_axis   out  m_axis_tvalid/tready    tdata = status, words, conversions
//
// One byte is accepted per cycle, back to back, unless a stall on m_axis
// backs up to the input; every byte flows through the input register and
// frame tracker, and each frame result then through the multiply stage and
// output register (3 stage registers after the input register); the constant
// multiply and the divide-by-65535 correction have a stage each.
// Reset (i_rst_n low, synchronous) empties all stages and returns the
// tracker to the first byte position with the CRC at 0xFF.
// A stall on m_axis backs up stage by stage; bubbles are squeezed out, and
// s_axis_tready falls only once every stage holds a transaction.
// ----------------------------------------------------------------------------
module sensor_frame_crc_convert_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [0] status, [16:1] temp_word,
                                        // [32:17] humidity_word,
                                        // [47:33] temp_centi_deg,
                                        // [61:48] humidity_centi_pct, [63:62] 0
);
    import sfc_pkg::*;

    // input register
    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_in_byte, n_in_byte;
    logic              r_in_start, n_in_start;

    logic       frm_ready;
    logic       fr_valid;
    t_frame_res fr_res;
    logic       conv_ready;

    assign s_axis_tready = !r_in_valid || frm_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        n_in_byte  = r_in_byte;
        n_in_start = r_in_start;
        if (s_axis_tready) begin
            n_in_valid = s_axis_tvalid;
            n_in_byte  = s_axis_tdata;
            n_in_start = s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte  <= n_in_byte;
        r_in_start <= n_in_start;
    end

    sfc_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (frm_ready),
        .i_byte  (r_in_byte),
        .i_start (r_in_start),
        .o_valid (fr_valid),
        .o_res   (fr_res),
        .i_ready (conv_ready)
    );

    sfc_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (conv_ready),
        .i_res   (fr_res),
        .o_valid (m_axis_tvalid),
        .o_tdata (m_axis_tdata),
        .i_ready (m_axis_tready)
    );

    // converted temperature stays within -45.00 .. 130.00 degrees
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[47:33]) >= -15'sd4500 &&
                           $signed(m_axis_tdata[47:33]) <= 15'sd13000))
        else $error("temperature conversion out of range");

    // converted humidity never exceeds 100.00 percent
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[61:48] <= 14'd10000))
        else $error("humidity conversion out of range");

    // a frame-start byte is a first byte and never closes a frame
    a_start_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_start && frm_ready) |=> !fr_valid)
        else $error("result produced on a frame-start byte");

    // pad bits of the result stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[63:62] == 2'b00))
        else $error("result pad bits set");

endmodule

### hw/rtl/sfc_frame.sv
// ----------------------------------------------------------------------------
// sfc_frame
// Frame tracker: byte position, running CRC, held words; emits one raw
// result on the humidity CRC byte.
// ----------------------------------------------------------------------------
module sfc_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte,
    input  logic                i_start,
    output logic                o_valid,
    output sfc_pkg::t_frame_res o_res,
    input  logic                i_ready
);
    import sfc_pkg::*;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_crc, n_crc;
    logic [WORD_W-1:0] r_temp_word, n_temp_word;
    logic [BYTE_W-1:0] r_hum_msb, n_hum_msb;
    logic [BYTE_W-1:0] r_hum_lsb, n_hum_lsb;
    logic              r_temp_bad, n_temp_bad;
    logic              r_valid, n_valid;
    t_frame_res        r_res, n_res;

    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] crc_step;
    logic              take;

    assign o_ready  = !r_valid || i_ready;
    assign take     = i_valid && o_ready;
    assign pos      = (i_start || r_pos > POS_HUM_CRC) ? POS_TEMP_MSB : r_pos;
    assign crc_step = crc8_byte((pos == POS_TEMP_MSB || pos == POS_HUM_MSB) ? CRC_INIT : r_crc,
                                i_byte);

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_temp_word = r_temp_word;
        n_hum_msb   = r_hum_msb;
        n_hum_lsb   = r_hum_lsb;
        n_temp_bad  = r_temp_bad;
        n_res       = r_res;
        n_valid     = r_valid && !i_ready;
        if (take) begin
            n_pos   = (pos == POS_HUM_CRC) ? POS_TEMP_MSB : pos + 3'd1;
            n_valid = (pos == POS_HUM_CRC);
            unique case (pos)
                POS_TEMP_MSB: begin
                    n_crc       = crc_step;
                    n_temp_word = {i_byte, 8'h00};
                end
                POS_TEMP_LSB: begin
                    n_crc       = crc_step;
                    n_temp_word = {r_temp_word[15:8], i_byte};
                end
                POS_TEMP_CRC: begin
                    n_temp_bad = (r_crc != i_byte);
                    n_crc      = CRC_INIT;
                end
                POS_HUM_MSB: begin
                    n_crc     = crc_step;
                    n_hum_msb = i_byte;
                end
                POS_HUM_LSB: begin
                    n_crc     = crc_step;
                    n_hum_lsb = i_byte;
                end
                default: begin
                    n_res.status        = r_temp_bad || (r_crc != i_byte);
                    n_res.temp_word     = r_temp_word;
                    n_res.humidity_word = {r_hum_msb, r_hum_lsb};
                    n_crc               = CRC_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_TEMP_MSB;
            r_crc      <= CRC_INIT;
            r_temp_bad <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_temp_bad <= n_temp_bad;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_temp_word <= n_temp_word;
        r_hum_msb   <= n_hum_msb;
        r_hum_lsb   <= n_hum_lsb;
        r_res       <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### hw/rtl/sfc_conv.sv
// ----------------------------------------------------------------------------
// sfc_conv
// Fixed-point conversion: constant multiply stage, then divide by 65535
// (shift plus one correction) into the output register.
// ----------------------------------------------------------------------------
module sfc_conv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sfc_pkg::t_frame_res i_res,
    output logic                o_valid,
    output logic [63:0]         o_tdata,
    input  logic                i_ready
);
    import sfc_pkg::*;

    // multiply stage
    logic              r_mul_valid, n_mul_valid;
    logic [TMUL_W-1:0] r_mul_t, n_mul_t;
    logic [HMUL_W-1:0] r_mul_h, n_mul_h;
    t_frame_res        r_mul_res, n_mul_res;

    // output stage
    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata, n_out_tdata;

    logic                   out_ready;
    logic [TEMP_W-1:0]      q0_t, q_t, temp_c;
    logic [HUM_W-1:0]       q0_h, q_h;
    logic [WORD_W:0]        rem_t, rem_h;

    assign out_ready = !r_out_valid || i_ready;
    assign o_ready   = !r_mul_valid || out_ready;

    // x / 65535 = (x >> 16) + 1 when (x mod 65536) + (x >> 16) >= 65535
    assign q0_t   = r_mul_t[TMUL_W-1:WORD_W];
    assign rem_t  = {1'b0, r_mul_t[WORD_W-1:0]} + {2'b00, q0_t};
    assign q_t    = q0_t + TEMP_W'(rem_t >= FULL_SCALE);
    assign temp_c = q_t - TEMP_OFFSET;   // wraps to 15-bit two's complement

    assign q0_h  = r_mul_h[HMUL_W-1:WORD_W];
    assign rem_h = {1'b0, r_mul_h[WORD_W-1:0]} + {3'b000, q0_h};
    assign q_h   = q0_h + HUM_W'(rem_h >= FULL_SCALE);

    always_comb begin
        n_mul_valid = r_mul_valid;
        n_mul_t     = r_mul_t;
        n_mul_h     = r_mul_h;
        n_mul_res   = r_mul_res;
        if (o_ready) begin
            n_mul_valid = i_valid;
            n_mul_t     = TMUL_W'(TEMP_SCALE) * TMUL_W'(i_res.temp_word);
            n_mul_h     = HMUL_W'(HUM_SCALE) * HMUL_W'(i_res.humidity_word);
            n_mul_res   = i_res;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_tdata = r_out_tdata;
        if (out_ready) begin
            n_out_valid = r_mul_valid;
            n_out_tdata = {2'b00, q_h, temp_c, r_mul_res.humidity_word,
                           r_mul_res.temp_word, r_mul_res.status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_valid <= n_mul_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul_t     <= n_mul_t;
        r_mul_h     <= n_mul_h;
        r_mul_res   <= n_mul_res;
        r_out_tdata <= n_out_tdata;
    end

    assign o_valid = r_out_valid;
    assign o_tdata = r_out_tdata;

endmodule

### tb/sv/sensor_frame_crc_convert_core_test.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_convert_core_test
// Self-checking bench for the sensor frame CRC check and conversion core.
// Sends frame bytes over s_axis and tracks each accepted byte with its own
// frame tracker: CRC-8, raw words and the two scaled values. It checks every
// m_axis result field by field, in order. A short table of directed frames
// comes first, then random frames with noise, under several idle and stall
// patterns.
// ----------------------------------------------------------------------------
module sensor_frame_crc_convert_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import sfc_pkg::*;

    localparam int unsigned DIRECTED_ROWS = 26;
    localparam int unsigned RANDOM_ITEMS  = 1924;
    localparam int unsigned PHASES        = 4;
    localparam int unsigned DRAIN_CYCLES  = 16;   // 4-stage pipe, plenty of margin

    // conversion constants, integer form of the float scaling
    localparam int unsigned TEMP_SPAN  = 17500;
    localparam int unsigned TEMP_BASE  = 4500;
    localparam int unsigned HUM_SPAN   = 10000;
    localparam int unsigned WORD_FULL  = 65535;

    // same bit layout as m_axis_tdata[61:0], status in bit 0
    typedef struct packed {
        logic [HUM_W-1:0]         humidity_centi_pct;
        logic signed [TEMP_W-1:0] temp_centi_deg;
        logic [WORD_W-1:0]        humidity_word;
        logic [WORD_W-1:0]        temp_word;
        logic                     status;
    } t_frame_result;

    typedef struct {
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_start;
        bit                typed;      // expected result written in the table
        t_frame_result     res;
    } t_stim_row;

    localparam t_frame_result NO_RESULT = '0;

    // ------------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] rx_byte
    logic        s_axis_tuser  = 1'b0;  // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // [0] status, [16:1] temp_word,
                                        // [32:17] humidity_word,
                                        // [47:33] temp_centi_deg,
                                        // [61:48] humidity_centi_pct, [63:62] 0

    sensor_frame_crc_convert_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_frame_result expected_frames[$];
    t_stim_row     directed_rows[$];
    int unsigned   items_sent     = 0;
    int unsigned   fail_count     = 0;
    int unsigned   send_idle_pct  = 0;
    int unsigned   recv_stall_pct = 0;

    // frame tracker state, mirrors the core after reset
    logic [POS_W-1:0]  trk_pos;
    logic [BYTE_W-1:0] trk_crc;
    logic [WORD_W-1:0] trk_temp;
    logic [BYTE_W-1:0] trk_hum_msb;
    logic [BYTE_W-1:0] trk_hum_lsb;
    logic              trk_temp_bad;

    // CRC-8 over one byte, bit serial, MSB first
    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        logic              fb;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb = c[BYTE_W-1] ^ data[i];
            c  = {c[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // Advance the tracker by one accepted byte; returns the frame result on
    // the humidity CRC byte.
    task automatic track_byte(input logic [BYTE_W-1:0] b, input logic start,
                              output bit produced, output t_frame_result res);
        logic [POS_W-1:0]  p;
        logic [WORD_W-1:0] hw;
        int unsigned       tq;
        int unsigned       hq;
        produced = 1'b0;
        res      = NO_RESULT;
        p        = trk_pos;
        // start flag resyncs; codes past the last byte count as the first
        if (start || p > POS_HUM_CRC)
            p = POS_TEMP_MSB;
        case (p)
            POS_TEMP_MSB: begin
                trk_crc  = crc8_step(CRC_INIT, b);
                trk_temp = {b, 8'h00};
            end
            POS_TEMP_LSB: begin
                trk_crc       = crc8_step(trk_crc, b);
                trk_temp[7:0] = b;
            end
            POS_TEMP_CRC: begin
                trk_temp_bad = (trk_crc != b);
                trk_crc      = CRC_INIT;
            end
            POS_HUM_MSB: begin
                trk_crc     = crc8_step(CRC_INIT, b);
                trk_hum_msb = b;
            end
            POS_HUM_LSB: begin
                trk_crc     = crc8_step(trk_crc, b);
                trk_hum_lsb = b;
            end
            default: begin
                hw = {trk_hum_msb, trk_hum_lsb};
                tq = (TEMP_SPAN * 32'(trk_temp)) / WORD_FULL;
                hq = (HUM_SPAN * 32'(hw)) / WORD_FULL;
                res.status             = trk_temp_bad || (trk_crc != b);
                res.temp_word          = trk_temp;
                res.humidity_word      = hw;
                res.temp_centi_deg     = TEMP_W'(tq - TEMP_BASE);
                res.humidity_centi_pct = HUM_W'(hq);
                produced = 1'b1;
                trk_crc  = CRC_INIT;
            end
        endcase
        trk_pos = (p == POS_HUM_CRC) ? POS_TEMP_MSB : p + 1'b1;
    endtask

    // One s_axis transaction. Entered and left just after a falling edge;
    // tvalid stays high into the next call unless a gap is drawn.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start,
                             input bit typed, input t_frame_result typed_res);
        bit            produced;
        t_frame_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tuser  = start;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        track_byte(b, start, produced, res);
        if (typed)
            expected_frames.push_back(typed_res);
        else if (produced)
            expected_frames.push_back(res);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic add_row(input logic [BYTE_W-1:0] b, input logic start,
                           input bit typed, input t_frame_result res);
        t_stim_row row;
        row.rx_byte     = b;
        row.frame_start = start;
        row.typed       = typed;
        row.res         = res;
        directed_rows.push_back(row);
    endtask

    // random word, biased toward the ends of the range and single-bit patterns
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001 << $urandom_range(15);
            3:       return ~(16'h0001 << $urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random backpressure, changed on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each m_axis transaction with the oldest expected frame result
    always @(posedge i_clk) begin : result_check
        t_frame_result got;
        t_frame_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[61:0];
            if (expected_frames.size() == 0) begin
                $error("unexpected result transaction, tdata 0x%h", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_frames.pop_front();
                if (got.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.temp_word !== want.temp_word) begin
                    $error("temp_word expected 0x%h got 0x%h",
                           want.temp_word, got.temp_word);
                    fail_count++;
                end
                if (got.humidity_word !== want.humidity_word) begin
                    $error("humidity_word expected 0x%h got 0x%h",
                           want.humidity_word, got.humidity_word);
                    fail_count++;
                end
                if (got.temp_centi_deg !== want.temp_centi_deg) begin
                    $error("temp_centi_deg expected %0d got %0d",
                           want.temp_centi_deg, got.temp_centi_deg);
                    fail_count++;
                end
                if (got.humidity_centi_pct !== want.humidity_centi_pct) begin
                    $error("humidity_centi_pct expected %0d got %0d",
                           want.humidity_centi_pct, got.humidity_centi_pct);
                    fail_count++;
                end
            end
            if (m_axis_tdata[63:62] !== 2'b00) begin
                $error("tdata pad expected 0 got %0d", m_axis_tdata[63:62]);
                fail_count++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [WORD_W-1:0] tw;
        logic [WORD_W-1:0] hw;
        logic [BYTE_W-1:0] tcrc;
        logic [BYTE_W-1:0] hcrc;
        logic              st;
        bit                aligned;
        int unsigned       target;

        trk_pos      = POS_TEMP_MSB;
        trk_crc      = CRC_INIT;
        trk_temp     = '0;
        trk_hum_msb  = '0;
        trk_hum_lsb  = '0;
        trk_temp_bad = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // all-zero words with good CRCs: lowest conversions
        add_row(8'h00, 1'b1, 0, NO_RESULT);
        add_row(8'h00, 1'b0, 0, NO_RESULT);
        add_row(8'h81, 1'b0, 0, NO_RESULT);
        add_row(8'h00, 1'b0, 0, NO_RESULT);
        add_row(8'h00, 1'b0, 0, NO_RESULT);
        add_row(8'h81, 1'b0, 1, '{status: 1'b0, temp_word: 16'h0000,
                humidity_word: 16'h0000, temp_centi_deg: -15'sd4500,
                humidity_centi_pct: 14'd0});
        // all-ones words, back to back with no start flag: full scale
        add_row(8'hFF, 1'b0, 0, NO_RESULT);
        add_row(8'hFF, 1'b0, 0, NO_RESULT);
        add_row(8'hAC, 1'b0, 0, NO_RESULT);
        add_row(8'hFF, 1'b0, 0, NO_RESULT);
        add_row(8'hFF, 1'b0, 0, NO_RESULT);
        add_row(8'hAC, 1'b0, 1, '{status: 1'b0, temp_word: 16'hFFFF,
                humidity_word: 16'hFFFF, temp_centi_deg: 15'sd13000,
                humidity_centi_pct: 14'd10000});
        // temperature CRC wrong, humidity CRC right: still flagged
        add_row(8'hFF, 1'b0, 0, NO_RESULT);
        add_row(8'hFF, 1'b0, 0, NO_RESULT);
        add_row(8'h00, 1'b0, 0, NO_RESULT);
        add_row(8'h00, 1'b0, 0, NO_RESULT);
        add_row(8'h00, 1'b0, 0, NO_RESULT);
        add_row(8'h81, 1'b0, 1, '{status: 1'b1, temp_word: 16'hFFFF,
                humidity_word: 16'h0000, temp_centi_deg: 15'sd13000,
                humidity_centi_pct: 14'd0});
        // partial frame dropped by a start flag, then a frame with a bad
        // humidity CRC, left to the tracker
        add_row(8'hBE, 1'b1, 0, NO_RESULT);
        add_row(8'hEF, 1'b0, 0, NO_RESULT);
        add_row(8'hBE, 1'b1, 0, NO_RESULT);
        add_row(8'hEF, 1'b0, 0, NO_RESULT);
        add_row(8'h92, 1'b0, 0, NO_RESULT);
        add_row(8'h12, 1'b0, 0, NO_RESULT);
        add_row(8'h34, 1'b0, 0, NO_RESULT);
        add_row(8'h00, 1'b0, 0, NO_RESULT);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx_byte, directed_rows[i].frame_start,
                      directed_rows[i].typed, directed_rows[i].res);

        aligned = 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            // hold off the sender until the pipe has drained
            s_axis_tvalid = 1'b0;
            while (expected_frames.size() != 0)
                @(posedge i_clk);
            @(negedge i_clk);

            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            endcase

            target = DIRECTED_ROWS + (ph + 1) * RANDOM_ITEMS / PHASES;
            while (items_sent < target) begin
                if ($urandom_range(99) < 80) begin
                    // well-formed frame, CRC bytes right most of the time
                    tw   = pick_word();
                    hw   = pick_word();
                    st   = aligned ? 1'($urandom_range(1)) : 1'b1;
                    tcrc = crc8_step(crc8_step(CRC_INIT, tw[15:8]), tw[7:0]);
                    hcrc = crc8_step(crc8_step(CRC_INIT, hw[15:8]), hw[7:0]);
                    if ($urandom_range(99) < 12)
                        tcrc = 8'($urandom);
                    if ($urandom_range(99) < 12)
                        hcrc = 8'($urandom);
                    send_byte(tw[15:8], st,   0, NO_RESULT);
                    send_byte(tw[7:0],  1'b0, 0, NO_RESULT);
                    send_byte(tcrc,     1'b0, 0, NO_RESULT);
                    send_byte(hw[15:8], 1'b0, 0, NO_RESULT);
                    send_byte(hw[7:0],  1'b0, 0, NO_RESULT);
                    send_byte(hcrc,     1'b0, 0, NO_RESULT);
                    aligned = 1'b1;
                end else begin
                    // noise: short runs of random bytes, stray start flags
                    repeat ($urandom_range(5, 1))
                        send_byte(8'($urandom), ($urandom_range(9) == 0), 0, NO_RESULT);
                    aligned = 1'b0;
                end
            end
        end

        // drain with the receiver always ready, then a quiet DRAIN_CYCLES wait
        s_axis_tvalid  = 1'b0;
        recv_stall_pct = 0;
        while (expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_frames.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #(8_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
